FILE: sv/plmd_pkg.sv
package plmd_pkg;

  localparam int MAX_POINTS_DEF = 128;

  localparam int OP_W    = 2;
  localparam int COORD_W = 16;
  localparam int DIST_W  = 24;
  localparam int STAT_W  = 2;

  localparam int CRD_W   = 18;
  localparam int DIF_W   = CRD_W + 1;
  localparam int PROD_W  = 2 * DIF_W;
  localparam int ACC_W   = 40;
  localparam int HALF_W  = 18;
  localparam int CC_W    = 70;
  localparam int FRAC_W  = 16;
  localparam int NUM_W   = CC_W + FRAC_W;
  localparam int DEN_W   = 36;
  localparam int SQ_W    = 48;
  localparam int SQRT_W  = SQ_W / 2;
  localparam int SUM_W   = SQ_W - FRAC_W;

  localparam logic signed [CRD_W-1:0] RAY_LOW  = -18'sd100000;
  localparam logic signed [CRD_W-1:0] RAY_HIGH = 18'sd100000;
  localparam logic [SQ_W-1:0]         SQ_MAX   = {SQ_W{1'b1}};

  localparam logic [OP_W-1:0] OP_LOAD_L  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_R  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED = 2'd2;

  localparam int ACC_N    = 6;
  localparam int ACC_LEN2 = 0;
  localparam int ACC_D1   = 1;
  localparam int ACC_D2   = 2;
  localparam int ACC_CR   = 3;
  localparam int ACC_EA   = 4;
  localparam int ACC_EB   = 5;

  localparam int CALC_STEPS = 12;
  localparam int SQR_STEPS  = 3;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_P, S_LD0, S_LDS, S_CALC, S_EVAL, S_SQR, S_DIVGO, S_DIVW,
    S_NEXT, S_SQRTGO, S_SQRTW, S_DONE
  } plmd_state_t;

  typedef struct packed {
    logic done;
    logic sat;
  } plmd_div_stat_t;

endpackage

FILE: sv/plmd_if.sv
interface plmd_in_if;
  logic                                valid;
  logic                                ready;
  logic [plmd_pkg::OP_W-1:0]           operation;
  logic signed [plmd_pkg::COORD_W-1:0] x_coord;
  logic signed [plmd_pkg::COORD_W-1:0] y_coord;
  modport source (output valid, operation, x_coord, y_coord, input ready);
  modport sink (input valid, operation, x_coord, y_coord, output ready);
endinterface

interface plmd_out_if;
  logic                        valid;
  logic                        ready;
  logic [plmd_pkg::DIST_W-1:0] least_dist;
  logic [plmd_pkg::STAT_W-1:0] status;
  modport source (output valid, least_dist, status, input ready);
  modport sink (input valid, least_dist, status, output ready);
endinterface

FILE: sv/polyline_min_distance_unit.sv
// Least distance between a left and a right polyline.
// in_ch: operation 0 appends a point to the left store, 1 to the right store,
//   2 starts a compute; x/y are ignored on compute. Loads are taken in the idle
//   state and never leave it; a load into a full store is dropped and flagged.
// out_ch: one transfer per compute: least_dist (8 fraction bits) and status.
// Compute walks every point of each side against every segment of the other
//   (L*(R+1) + R*(L+1) pairs) on the shared 19x19 multiplier; a pair where the
//   point lies over the segment adds a pass through the 1-bit-per-cycle
//   divider. A square root ends it.
// in_ch.ready is low from the compute transfer until the result is in the
//   output register; an empty side skips the walk and goes straight to the result.
// The result waits in the output register while out_ch.ready is low; loads
//   are still taken, a further compute holds its result until the slot frees.
// Reset clears counts, flag and output valid; store contents stay undefined.
module polyline_min_distance_unit #(
  parameter int MAX_POINTS = plmd_pkg::MAX_POINTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  plmd_in_if.sink      in_ch,
  plmd_out_if.source   out_ch
);
  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int CRW   = plmd_pkg::COORD_W;
  localparam int MW    = 2 * CRW;
  localparam int CRD_W = plmd_pkg::CRD_W;
  localparam int DIF_W = plmd_pkg::DIF_W;
  localparam int ACC_W = plmd_pkg::ACC_W;
  localparam int SQ_W  = plmd_pkg::SQ_W;
  localparam int HW    = plmd_pkg::HALF_W;
  localparam int CCW   = plmd_pkg::CC_W;

  plmd_pkg::plmd_state_t state_r, state_nxt;
  logic [CW-1:0] lcnt_r, lcnt_nxt, rcnt_r, rcnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] pn, sn, i1, j1;
  logic          drop_r, drop_nxt, pass_r, pass_nxt, out_valid_r, out_valid_nxt;
  logic [3:0]    step_r, step_nxt, k;
  logic [2:0]    acc_idx;

  logic signed [CRD_W-1:0] px_r, px_nxt, py_r, py_nxt, ax_r, ax_nxt, ay_r, ay_nxt;
  logic signed [CRD_W-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic signed [CRD_W-1:0] curx_r, curx_nxt, cury_r, cury_nxt;
  logic signed [ACC_W-1:0] acc_r [plmd_pkg::ACC_N];
  logic signed [ACC_W-1:0] acc_nxt [plmd_pkg::ACC_N];
  logic signed [ACC_W-1:0] prod_ext;
  logic [ACC_W-1:0]        cr_mag;
  logic [CCW-1:0]          cc_r, cc_nxt, prod_cc;
  logic [SQ_W-1:0]         best_r, best_nxt, ea_s, eb_s, e_min, dv;
  logic [plmd_pkg::DIST_W-1:0] res_dist_r, res_dist_nxt, out_dist_r, out_dist_nxt;
  logic [plmd_pkg::STAT_W-1:0] res_stat_r, res_stat_nxt, out_stat_r, out_stat_nxt;

  logic          l_we, r_we;
  logic [AW-1:0] l_addr, r_addr, p_addr, s_addr;
  logic [MW-1:0] wdata, l_rdata, r_rdata, p_rd, s_rd;
  logic signed [CRW-1:0]   p_x16, p_y16, s_x16, s_y16;
  logic signed [CRD_W-1:0] p_x, p_y, s_x, s_y;

  logic signed [DIF_W-1:0] d_ux, d_uy, d_pax, d_pay, d_pbx, d_pby, d_abx, d_aby;
  logic signed [DIF_W-1:0] mul_a, mul_b;
  logic signed [plmd_pkg::PROD_W-1:0] prod;

  logic                     div_start, sq_start, sq_done, in_xfer, interior;
  logic [SQ_W-1:0]          div_q;
  plmd_pkg::plmd_div_stat_t div_stat;
  logic [plmd_pkg::SQRT_W-1:0] sq_root;

  plmd_ram #(.WIDTH(MW), .DEPTH(MAX_POINTS)) u_left (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(wdata), .rdata(l_rdata)
  );
  plmd_ram #(.WIDTH(MW), .DEPTH(MAX_POINTS)) u_right (
    .clk(clk), .we(r_we), .addr(r_addr), .wdata(wdata), .rdata(r_rdata)
  );
  plmd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));
  plmd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num({cc_r, {plmd_pkg::FRAC_W{1'b0}}}),
    .den(acc_r[plmd_pkg::ACC_LEN2][plmd_pkg::DEN_W-1:0]),
    .q(div_q), .stat(div_stat)
  );
  plmd_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .v(best_r),
    .root(sq_root), .done(sq_done)
  );

  assign in_ch.ready       = (state_r == plmd_pkg::S_IDLE);
  assign in_xfer           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.least_dist = out_dist_r;
  assign out_ch.status     = out_stat_r;
  assign wdata             = {in_ch.x_coord, in_ch.y_coord};

  assign pn    = pass_r ? rcnt_r : lcnt_r;
  assign sn    = pass_r ? lcnt_r : rcnt_r;
  assign i1    = i_r + 1'b1;
  assign j1    = j_r + 1'b1;
  assign p_rd  = pass_r ? r_rdata : l_rdata;
  assign s_rd  = pass_r ? l_rdata : r_rdata;
  assign p_x16 = p_rd[MW-1:CRW];
  assign p_y16 = p_rd[CRW-1:0];
  assign s_x16 = s_rd[MW-1:CRW];
  assign s_y16 = s_rd[CRW-1:0];
  assign p_x   = CRD_W'(p_x16);
  assign p_y   = CRD_W'(p_y16);
  assign s_x   = CRD_W'(s_x16);
  assign s_y   = CRD_W'(s_y16);

  assign d_ux  = DIF_W'(bx_r) - DIF_W'(ax_r);
  assign d_uy  = DIF_W'(by_r) - DIF_W'(ay_r);
  assign d_abx = DIF_W'(ax_r) - DIF_W'(bx_r);
  assign d_aby = DIF_W'(ay_r) - DIF_W'(by_r);
  assign d_pax = DIF_W'(px_r) - DIF_W'(ax_r);
  assign d_pay = DIF_W'(py_r) - DIF_W'(ay_r);
  assign d_pbx = DIF_W'(px_r) - DIF_W'(bx_r);
  assign d_pby = DIF_W'(py_r) - DIF_W'(by_r);

  assign cr_mag = acc_r[plmd_pkg::ACC_CR][ACC_W-1] ? ACC_W'(-acc_r[plmd_pkg::ACC_CR])
                                                   : ACC_W'(acc_r[plmd_pkg::ACC_CR]);
  assign interior = (acc_r[plmd_pkg::ACC_LEN2] > 0) && !acc_r[plmd_pkg::ACC_D1][ACC_W-1]
                    && !acc_r[plmd_pkg::ACC_D2][ACC_W-1];
  assign ea_s  = (|acc_r[plmd_pkg::ACC_EA][ACC_W-1:plmd_pkg::SUM_W]) ? plmd_pkg::SQ_MAX :
                 {acc_r[plmd_pkg::ACC_EA][plmd_pkg::SUM_W-1:0], {plmd_pkg::FRAC_W{1'b0}}};
  assign eb_s  = (|acc_r[plmd_pkg::ACC_EB][ACC_W-1:plmd_pkg::SUM_W]) ? plmd_pkg::SQ_MAX :
                 {acc_r[plmd_pkg::ACC_EB][plmd_pkg::SUM_W-1:0], {plmd_pkg::FRAC_W{1'b0}}};
  assign e_min = (ea_s < eb_s) ? ea_s : eb_s;
  assign dv    = div_stat.sat ? plmd_pkg::SQ_MAX : div_q;

  assign k        = step_r - 1'b1;
  assign acc_idx  = k[3:1];
  assign prod_ext = ACC_W'(prod);
  assign prod_cc  = CCW'(prod[plmd_pkg::PROD_W-2:0]);

  assign l_addr = (state_r == plmd_pkg::S_IDLE) ? lcnt_r[AW-1:0] : (pass_r ? s_addr : p_addr);
  assign r_addr = (state_r == plmd_pkg::S_IDLE) ? rcnt_r[AW-1:0] : (pass_r ? p_addr : s_addr);

  always_comb begin
    state_nxt     = state_r;
    lcnt_nxt      = lcnt_r;
    rcnt_nxt      = rcnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    drop_nxt      = drop_r;
    pass_nxt      = pass_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    px_nxt = px_r; py_nxt = py_r; ax_nxt = ax_r; ay_nxt = ay_r;
    bx_nxt = bx_r; by_nxt = by_r; curx_nxt = curx_r; cury_nxt = cury_r;
    acc_nxt      = acc_r;
    cc_nxt       = cc_r;
    best_nxt     = best_r;
    res_dist_nxt = res_dist_r;
    res_stat_nxt = res_stat_r;
    out_dist_nxt = out_dist_r;
    out_stat_nxt = out_stat_r;
    l_we      = 1'b0;
    r_we      = 1'b0;
    p_addr    = '0;
    s_addr    = '0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    sq_start  = 1'b0;

    unique case (state_r)
      plmd_pkg::S_IDLE: begin
        if (in_xfer) begin
          priority case (in_ch.operation)
            plmd_pkg::OP_LOAD_L: begin
              if (lcnt_r < CW'(MAX_POINTS)) begin
                l_we     = 1'b1;
                lcnt_nxt = lcnt_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            plmd_pkg::OP_LOAD_R: begin
              if (rcnt_r < CW'(MAX_POINTS)) begin
                r_we     = 1'b1;
                rcnt_nxt = rcnt_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            plmd_pkg::OP_COMPUTE: begin
              if ((lcnt_r == '0) || (rcnt_r == '0)) begin
                res_dist_nxt = '0;
                res_stat_nxt = plmd_pkg::ST_EMPTY;
                state_nxt    = plmd_pkg::S_DONE;
              end else begin
                best_nxt  = plmd_pkg::SQ_MAX;
                pass_nxt  = 1'b0;
                i_nxt     = '0;
                j_nxt     = '0;
                state_nxt = plmd_pkg::S_RD_P;
              end
            end
            default: ;
          endcase
        end
      end
      plmd_pkg::S_RD_P: begin
        p_addr    = i_r[AW-1:0];
        state_nxt = plmd_pkg::S_LD0;
      end
      plmd_pkg::S_LD0: begin
        px_nxt = p_x; py_nxt = p_y;
        curx_nxt = s_x; cury_nxt = s_y;
        ax_nxt = s_x; ay_nxt = plmd_pkg::RAY_LOW; bx_nxt = s_x; by_nxt = s_y;
        step_nxt  = '0;
        state_nxt = plmd_pkg::S_CALC;
      end
      plmd_pkg::S_LDS: begin
        ax_nxt = curx_r; ay_nxt = cury_r; bx_nxt = s_x; by_nxt = s_y;
        curx_nxt = s_x; cury_nxt = s_y;
        step_nxt  = '0;
        state_nxt = plmd_pkg::S_CALC;
      end
      plmd_pkg::S_CALC: begin
        unique case (step_r)
          4'd0:  begin mul_a = d_ux;  mul_b = d_ux;  end
          4'd1:  begin mul_a = d_uy;  mul_b = d_uy;  end
          4'd2:  begin mul_a = d_ux;  mul_b = d_pax; end
          4'd3:  begin mul_a = d_uy;  mul_b = d_pay; end
          4'd4:  begin mul_a = d_abx; mul_b = d_pbx; end
          4'd5:  begin mul_a = d_aby; mul_b = d_pby; end
          4'd6:  begin mul_a = d_pax; mul_b = d_pby; end
          4'd7:  begin mul_a = d_pay; mul_b = d_pbx; end
          4'd8:  begin mul_a = d_pax; mul_b = d_pax; end
          4'd9:  begin mul_a = d_pay; mul_b = d_pay; end
          4'd10: begin mul_a = d_pbx; mul_b = d_pbx; end
          4'd11: begin mul_a = d_pby; mul_b = d_pby; end
          default: ;
        endcase
        if (step_r != '0) begin
          if (!k[0]) begin
            acc_nxt[acc_idx] = prod_ext;
          end else if (acc_idx == 3'(plmd_pkg::ACC_CR)) begin
            acc_nxt[acc_idx] = acc_r[acc_idx] - prod_ext;
          end else begin
            acc_nxt[acc_idx] = acc_r[acc_idx] + prod_ext;
          end
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 4'(plmd_pkg::CALC_STEPS)) begin
          step_nxt  = '0;
          state_nxt = plmd_pkg::S_EVAL;
        end
      end
      plmd_pkg::S_EVAL: begin
        if (interior) begin
          step_nxt  = '0;
          state_nxt = plmd_pkg::S_SQR;
        end else begin
          if (e_min < best_r) begin
            best_nxt = e_min;
          end
          state_nxt = plmd_pkg::S_NEXT;
        end
      end
      plmd_pkg::S_SQR: begin
        // c^2 from an 18-bit low half a0 and a 17-bit high half a1: a1^2<<36 + a0*a1<<19 + a0^2
        unique case (step_r)
          4'd0: begin
            mul_a = DIF_W'({1'b0, cr_mag[HW-1:0]});
            mul_b = DIF_W'({1'b0, cr_mag[HW-1:0]});
          end
          4'd1: begin
            mul_a = DIF_W'({1'b0, cr_mag[HW-1:0]});
            mul_b = DIF_W'({2'b0, cr_mag[2*HW-2:HW]});
          end
          4'd2: begin
            mul_a = DIF_W'({2'b0, cr_mag[2*HW-2:HW]});
            mul_b = DIF_W'({2'b0, cr_mag[2*HW-2:HW]});
          end
          default: ;
        endcase
        unique case (step_r)
          4'd1:    cc_nxt = prod_cc;
          4'd2:    cc_nxt = cc_r + (prod_cc << (HW + 1));
          4'd3:    cc_nxt = cc_r + (prod_cc << (2 * HW));
          default: ;
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r == 4'(plmd_pkg::SQR_STEPS)) begin
          state_nxt = plmd_pkg::S_DIVGO;
        end
      end
      plmd_pkg::S_DIVGO: begin
        div_start = 1'b1;
        state_nxt = plmd_pkg::S_DIVW;
      end
      plmd_pkg::S_DIVW: begin
        if (div_stat.done) begin
          if (dv < best_r) begin
            best_nxt = dv;
          end
          state_nxt = plmd_pkg::S_NEXT;
        end
      end
      plmd_pkg::S_NEXT: begin
        if (j_r < sn) begin
          j_nxt = j1;
          if (j1 < sn) begin
            s_addr    = j1[AW-1:0];
            state_nxt = plmd_pkg::S_LDS;
          end else begin
            ax_nxt = curx_r; ay_nxt = cury_r; bx_nxt = curx_r;
            by_nxt = plmd_pkg::RAY_HIGH;
            step_nxt  = '0;
            state_nxt = plmd_pkg::S_CALC;
          end
        end else if (i1 < pn) begin
          i_nxt     = i1;
          j_nxt     = '0;
          state_nxt = plmd_pkg::S_RD_P;
        end else if (!pass_r) begin
          pass_nxt  = 1'b1;
          i_nxt     = '0;
          j_nxt     = '0;
          state_nxt = plmd_pkg::S_RD_P;
        end else begin
          state_nxt = plmd_pkg::S_SQRTGO;
        end
      end
      plmd_pkg::S_SQRTGO: begin
        sq_start  = 1'b1;
        state_nxt = plmd_pkg::S_SQRTW;
      end
      plmd_pkg::S_SQRTW: begin
        if (sq_done) begin
          res_dist_nxt = sq_root;
          res_stat_nxt = drop_r ? plmd_pkg::ST_DROPPED : plmd_pkg::ST_OK;
          state_nxt    = plmd_pkg::S_DONE;
        end
      end
      plmd_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = res_dist_r;
          out_stat_nxt  = res_stat_r;
          lcnt_nxt      = '0;
          rcnt_nxt      = '0;
          drop_nxt      = 1'b0;
          state_nxt     = plmd_pkg::S_IDLE;
        end
      end
      default: state_nxt = plmd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plmd_pkg::S_IDLE;
      lcnt_r      <= '0;
      rcnt_r      <= '0;
      i_r         <= '0;
      j_r         <= '0;
      drop_r      <= 1'b0;
      pass_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcnt_r      <= lcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      drop_r      <= drop_nxt;
      pass_r      <= pass_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt; py_r <= py_nxt; ax_r <= ax_nxt; ay_r <= ay_nxt;
    bx_r <= bx_nxt; by_r <= by_nxt; curx_r <= curx_nxt; cury_r <= cury_nxt;
    acc_r      <= acc_nxt;
    cc_r       <= cc_nxt;
    best_r     <= best_nxt;
    res_dist_r <= res_dist_nxt;
    res_stat_r <= res_stat_nxt;
    out_dist_r <= out_dist_nxt;
    out_stat_r <= out_stat_nxt;
  end
endmodule

FILE: sv/plmd_ram.sv
module plmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = plmd_pkg::MAX_POINTS_DEF
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                           wdata,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: sv/plmd_mul.sv
module plmd_mul (
  input  logic                                clk,
  input  logic signed [plmd_pkg::DIF_W-1:0]   a,
  input  logic signed [plmd_pkg::DIF_W-1:0]   b,
  output logic signed [plmd_pkg::PROD_W-1:0]  p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

FILE: sv/plmd_div.sv
module plmd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [plmd_pkg::NUM_W-1:0]    num,
  input  logic [plmd_pkg::DEN_W-1:0]    den,
  output logic [plmd_pkg::SQ_W-1:0]     q,
  output plmd_pkg::plmd_div_stat_t      stat
);
  localparam int NW = plmd_pkg::NUM_W;
  localparam int DW = plmd_pkg::DEN_W;
  localparam int QW = plmd_pkg::SQ_W;
  localparam int KW = $clog2(NW + 1);

  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r, den_nxt, rem_r, rem_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt, sat_r, sat_nxt;
  logic [DW:0]   sh, dif;
  logic          ge;

  always_comb begin
    sh       = {rem_r, num_r[NW-1]};
    dif      = sh - {1'b0, den_r};
    ge       = (sh >= {1'b0, den_r});
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sat_nxt  = sat_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = KW'(NW);
      busy_nxt = 1'b1;
      sat_nxt  = 1'b0;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      rem_nxt = ge ? dif[DW-1:0] : sh[DW-1:0];
      q_nxt   = {q_r[QW-2:0], ge};
      if (ge && (cnt_r > KW'(QW))) begin
        sat_nxt = 1'b1;
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == KW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
  end

  assign q         = q_r;
  assign stat.done = done_r;
  assign stat.sat  = sat_r;
endmodule

FILE: sv/plmd_sqrt.sv
module plmd_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [plmd_pkg::SQ_W-1:0]     v,
  output logic [plmd_pkg::SQRT_W-1:0]   root,
  output logic                          done
);
  localparam int VW = plmd_pkg::SQ_W;
  localparam int RW = plmd_pkg::SQRT_W;
  localparam int EW = RW + 3;
  localparam int KW = $clog2(RW + 1);

  logic [VW-1:0] v_r, v_nxt;
  logic [EW-1:0] rem_r, rem_nxt, rem_sh, trial;
  logic [RW-1:0] root_r, root_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt, ge;

  always_comb begin
    rem_sh   = {rem_r[EW-3:0], v_r[VW-1:VW-2]};
    trial    = EW'({root_r, 2'b01});
    ge       = (rem_sh >= trial);
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = v;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = KW'(RW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      v_nxt    = {v_r[VW-3:0], 2'b00};
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[RW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == KW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign done = done_r;
endmodule

FILE: sv/plmd_checker.sv
module plmd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [plmd_pkg::OP_W-1:0]   in_operation,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [plmd_pkg::DIST_W-1:0] out_least_dist,
  input logic [plmd_pkg::STAT_W-1:0] out_status
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_least_dist) && $stable(out_status))
    else $error("result dropped or changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == plmd_pkg::OP_COMPUTE) |=> !in_ready)
    else $error("ready right after compute transfer");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == plmd_pkg::ST_EMPTY) |-> (out_least_dist == '0))
    else $error("empty side with nonzero distance");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == plmd_pkg::ST_OK) || (out_status == plmd_pkg::ST_EMPTY)
                  || (out_status == plmd_pkg::ST_DROPPED))
    else $error("bad status code");
endmodule

bind polyline_min_distance_unit plmd_checker u_plmd_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .in_operation(in_ch.operation),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_least_dist(out_ch.least_dist),
  .out_status(out_ch.status)
);
